@@ rtl/chtr_pkg.sv @@
// Shared codes, field widths and state type of the clustered hash table core.
package chtr_pkg;

    // Field widths of one beat
    localparam int ACTION_W  = 2;
    localparam int CLUSTER_W = 16;
    localparam int FRAG_W    = 16;
    localparam int WAY_W     = 2;
    localparam int MOVE_W    = 16;
    localparam int SCORE_W   = 16;
    localparam int DEPTH_W   = 8;
    localparam int FLAG_W    = 2;

    // Action codes
    localparam logic [ACTION_W-1:0] ACT_PROBE = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_SAVE  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_AGE   = 2'd2;

    // Bound flag code that always forces replacement
    localparam logic [FLAG_W-1:0] FLAG_EXACT = 2'd1;

    // Tag value of an empty way
    localparam logic [FRAG_W-1:0] FRAG_EMPTY = 16'd0;

    // Replacement constants: depth margin, extra margin on the PV, age weight shift (x8)
    localparam int DEPTH_MARGIN = 3;
    localparam int PV_MARGIN    = 2;
    localparam int AGE_SHIFT    = 3;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_EVAL
    } t_state;

endpackage

@@ rtl/clustered_hash_table_replacement_core.sv @@
// Clustered hash table core: cluster RAM, way selection and depth/age replacement.
//
// Each item is handled in steps: the beat is taken, the next cycle reads the whole
// cluster row from the cluster RAM, and the cycle after selects the way, writes
// the row back on a save and loads the result register once the output is free,
// taking the next beat in the same cycle. No new beat is taken while a row is
// being read, as each item reads and then writes one RAM row. After reset the
// core sweeps all CLUSTERS clusters (65536 by default) to zero, one cluster a
// cycle, and stalls the input until the sweep ends.
module clustered_hash_table_replacement_core
    import chtr_pkg::*;
#(
    parameter int CLUSTERS   = 65536,
    parameter int WAYS       = 3,
    parameter int AGE_PERIOD = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // input channel
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [ACTION_W-1:0]       i_action,
    input  logic [CLUSTER_W-1:0]      i_cluster_index,
    input  logic [FRAG_W-1:0]         i_fragment,
    input  logic [WAY_W-1:0]          i_way,
    input  logic [MOVE_W-1:0]         i_new_move,
    input  logic signed [SCORE_W-1:0] i_new_score,
    input  logic [DEPTH_W-1:0]        i_new_depth,
    input  logic [FLAG_W-1:0]         i_new_flag,
    input  logic                      i_in_pv,
    // output channel
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic                      o_hit,
    output logic [WAY_W-1:0]          o_chosen_way,
    output logic [MOVE_W-1:0]         o_entry_move,
    output logic signed [SCORE_W-1:0] o_entry_score,
    output logic [DEPTH_W-1:0]        o_entry_depth,
    output logic [FLAG_W-1:0]         o_entry_flag
);

    localparam int CW  = $clog2(CLUSTERS);
    localparam int WIW = $clog2(WAYS);
    localparam int AW  = $clog2(AGE_PERIOD);
    localparam int QW  = ((AW + AGE_SHIFT) > DEPTH_W ? (AW + AGE_SHIFT) : DEPTH_W) + 1;
    localparam bit NEED_MOD = (CLUSTERS < (1 << CLUSTER_W));
    localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(CLUSTERS));

    typedef struct packed {
        logic [FRAG_W-1:0]         frag;
        logic [MOVE_W-1:0]         move;
        logic signed [SCORE_W-1:0] score;
        logic [DEPTH_W-1:0]        depth;
        logic [FLAG_W-1:0]         flag;
        logic [AW-1:0]             age;
    } t_entry;

    typedef t_entry [WAYS-1:0] t_row;

    // Sequencer and control registers
    t_state        r_state, n_state;
    logic [CW-1:0] r_clr_idx;
    logic [AW-1:0] r_age;
    logic          r_out_valid;

    // Registered beat
    logic [ACTION_W-1:0]       r_action;
    logic [CLUSTER_W-1:0]      r_cidx;
    logic [CLUSTER_W-1:0]      r_qest;
    logic [FRAG_W-1:0]         r_frag;
    logic [WAY_W-1:0]          r_way;
    logic [MOVE_W-1:0]         r_move;
    logic signed [SCORE_W-1:0] r_score;
    logic [DEPTH_W-1:0]        r_depth;
    logic [FLAG_W-1:0]         r_flag;
    logic                      r_pv;
    logic [CW-1:0]             r_row;

    // Result registers
    logic                      r_hit;
    logic [WAY_W-1:0]          r_cway;
    logic [MOVE_W-1:0]         r_emove;
    logic signed [SCORE_W-1:0] r_escore;
    logic [DEPTH_W-1:0]        r_edepth;
    logic [FLAG_W-1:0]         r_eflag;

    // Cluster RAM
    t_row          mem [CLUSTERS];
    t_row          r_rd_row;
    logic          mem_re;
    logic          mem_we;
    logic [CW-1:0] mem_waddr;
    t_row          mem_wdata;

    // Control
    logic          in_acc;
    logic          out_free;
    logic          out_load;
    logic [47:0]   qest_prod;
    logic [31:0]   red_diff;
    logic [CW-1:0] red_idx;

    // Evaluation results
    logic          ev_hit;
    logic [WAY_W-1:0] ev_way;
    t_entry        ev_entry;
    logic          ev_write;
    t_row          ev_row;

    assign in_acc   = i_valid && !o_stall;
    assign out_free = !r_out_valid || !i_stall;

    // Quotient estimate of the cluster reduction, taken at the input beat
    assign qest_prod = 48'(i_cluster_index) * 48'(RECIP);

    // Finish the cluster reduction: remainder with one correction step
    always_comb begin
        red_diff = 32'(r_cidx) - 32'(r_qest) * 32'(CLUSTERS);
        if (red_diff >= 32'(CLUSTERS)) begin
            red_diff = red_diff - 32'(CLUSTERS);
        end
        red_idx = NEED_MOD ? CW'(red_diff) : CW'(r_cidx);
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr_idx == CW'(CLUSTERS - 1)) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (in_acc) n_state = ST_READ;
            end
            ST_READ: begin
                n_state = ST_EVAL;
            end
            ST_EVAL: begin
                if (out_load) n_state = in_acc ? ST_READ : ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb begin
        o_stall  = 1'b1;
        out_load = 1'b0;
        mem_re   = 1'b0;
        mem_we   = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                mem_we = 1'b1;
            end
            ST_IDLE: begin
                o_stall = 1'b0;
            end
            ST_READ: begin
                mem_re = 1'b1;
            end
            ST_EVAL: begin
                out_load = out_free;
                o_stall  = !out_free;
                mem_we   = out_free && ev_write;
            end
            default: begin
                o_stall = 1'b1;
            end
        endcase
    end

    assign mem_waddr = (r_state == ST_CLEAR) ? r_clr_idx : r_row;
    assign mem_wdata = (r_state == ST_CLEAR) ? '0 : ev_row;

    // Select the way on a probe, merge the entry on a save
    always_comb begin
        logic [AW:0]         dist_wrap;
        logic [AW-1:0]       age_gap;
        logic signed [QW-1:0] qual [WAYS];
        logic signed [QW-1:0] low;
        logic [WIW-1:0]      pick;
        logic                found;
        logic [WIW-1:0]      sw;
        t_entry              old_e;
        t_entry              new_e;
        logic                matched;
        logic [DEPTH_W+1:0]  depth_sum;

        ev_hit   = 1'b0;
        ev_way   = '0;
        ev_entry = '0;
        ev_write = 1'b0;
        ev_row   = r_rd_row;

        // quality of every way: depth - 8 * age distance
        for (int i = 0; i < WAYS; i++) begin
            dist_wrap = {1'b0, r_age} + (AW + 1)'(AGE_PERIOD) - {1'b0, r_rd_row[i].age};
            age_gap = (r_age >= r_rd_row[i].age) ? (r_age - r_rd_row[i].age) : AW'(dist_wrap);
            qual[i] = $signed(QW'(r_rd_row[i].depth)) - $signed(QW'(age_gap) << AGE_SHIFT);
        end

        // first empty or matching way, else lowest quality, earliest on ties
        pick  = '0;
        low   = qual[0];
        found = (r_rd_row[0].frag == FRAG_EMPTY) || (r_rd_row[0].frag == r_frag);
        for (int i = 1; i < WAYS; i++) begin
            if (!found) begin
                if ((r_rd_row[i].frag == FRAG_EMPTY) || (r_rd_row[i].frag == r_frag)) begin
                    pick  = WIW'(i);
                    found = 1'b1;
                end else if (qual[i] < low) begin
                    low  = qual[i];
                    pick = WIW'(i);
                end
            end
        end

        // save merge on the addressed way
        sw        = WIW'(r_way);
        old_e     = r_rd_row[sw];
        new_e     = old_e;
        matched   = (old_e.frag == r_frag);
        depth_sum = (DEPTH_W + 2)'(r_depth) + (DEPTH_W + 2)'(DEPTH_MARGIN)
                  + (r_pv ? (DEPTH_W + 2)'(PV_MARGIN) : '0);
        if ((r_move != '0) || !matched) begin
            new_e.move = r_move;
        end
        if (!matched || (r_flag == FLAG_EXACT) || (depth_sum >= (DEPTH_W + 2)'(old_e.depth))
                || (old_e.age != r_age)) begin
            new_e.age   = r_age;
            new_e.score = r_score;
            new_e.depth = r_depth;
            new_e.flag  = r_flag;
            new_e.frag  = r_frag;
        end

        case (r_action)
            ACT_PROBE: begin
                ev_hit   = (r_rd_row[pick].frag == r_frag);
                ev_way   = WAY_W'(pick);
                ev_entry = r_rd_row[pick];
            end
            ACT_SAVE: begin
                if (4'(r_way) < 4'(WAYS)) begin
                    ev_write   = 1'b1;
                    ev_way     = r_way;
                    ev_entry   = new_e;
                    ev_row[sw] = new_e;
                end
            end
            default: begin
                ev_write = 1'b0;
            end
        endcase
    end

    // Cluster RAM: one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        if (mem_re) r_rd_row <= mem[red_idx];
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_idx   <= '0;
            r_age       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) r_clr_idx <= r_clr_idx + 1'b1;
            // advance the generation when an age beat completes
            if (out_load && (r_action == ACT_AGE)) begin
                r_age <= (r_age == AW'(AGE_PERIOD - 1)) ? '0 : r_age + 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Capture the input beat and the reduced cluster row
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_action <= i_action;
            r_cidx   <= i_cluster_index;
            r_qest   <= qest_prod[47:32];
            r_frag   <= i_fragment;
            r_way    <= i_way;
            r_move   <= i_new_move;
            r_score  <= i_new_score;
            r_depth  <= i_new_depth;
            r_flag   <= i_new_flag;
            r_pv     <= i_in_pv;
        end
        if (r_state == ST_READ) r_row <= red_idx;
    end

    // Result register: hold while the output beat is stalled
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_hit    <= ev_hit;
            r_cway   <= ev_way;
            r_emove  <= ev_entry.move;
            r_escore <= ev_entry.score;
            r_edepth <= ev_entry.depth;
            r_eflag  <= ev_entry.flag;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_hit         = r_hit;
    assign o_chosen_way  = r_cway;
    assign o_entry_move  = r_emove;
    assign o_entry_score = r_escore;
    assign o_entry_depth = r_edepth;
    assign o_entry_flag  = r_eflag;

`ifndef SYNTHESIS
    // No beat is taken while the RAM sweep runs
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> o_stall)
        else $error("input beat taken during RAM clear");

    // An accepted beat always reads its cluster next
    a_accept_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == ST_READ))
        else $error("accepted beat did not start a cluster read");

    // RAM writes only during the sweep or the evaluation of a save
    a_write_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> ((r_state == ST_CLEAR) || ((r_state == ST_EVAL) && (r_action == ACT_SAVE))))
        else $error("cluster RAM written outside a save or clear");

    // A new result follows an evaluation cycle
    a_result_from_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !$past(o_valid)) |-> ($past(r_state) == ST_EVAL))
        else $error("result appeared without an evaluation");
`endif

endmodule

@@ sim/hash_table_checker.sv @@
// Channel monitor for the clustered hash table core: predicts each result beat and compares it.
module hash_table_checker
    import chtr_pkg::*;
#(
    parameter int CLUSTERS   = 65536,
    parameter int WAYS       = 3,
    parameter int AGE_PERIOD = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // input channel of the core
    input  logic                      i_in_valid,
    input  logic                      i_in_stall,
    input  logic [ACTION_W-1:0]       i_action,
    input  logic [CLUSTER_W-1:0]      i_cluster_index,
    input  logic [FRAG_W-1:0]         i_fragment,
    input  logic [WAY_W-1:0]          i_way,
    input  logic [MOVE_W-1:0]         i_new_move,
    input  logic signed [SCORE_W-1:0] i_new_score,
    input  logic [DEPTH_W-1:0]        i_new_depth,
    input  logic [FLAG_W-1:0]         i_new_flag,
    input  logic                      i_in_pv,
    // output channel of the core
    input  logic                      i_out_valid,
    input  logic                      i_out_stall,
    input  logic                      i_hit,
    input  logic [WAY_W-1:0]          i_chosen_way,
    input  logic [MOVE_W-1:0]         i_entry_move,
    input  logic signed [SCORE_W-1:0] i_entry_score,
    input  logic [DEPTH_W-1:0]        i_entry_depth,
    input  logic [FLAG_W-1:0]         i_entry_flag,
    // status towards the testbench top
    output int                        o_fail_count,
    output int                        o_pending,
    output int                        o_checked
);

    localparam int AGE_W = $clog2(AGE_PERIOD);

    typedef struct packed {
        logic [FRAG_W-1:0]         frag;
        logic [MOVE_W-1:0]         move;
        logic signed [SCORE_W-1:0] score;
        logic [DEPTH_W-1:0]        depth;
        logic [FLAG_W-1:0]         flag;
        logic [AGE_W-1:0]          age;
    } slot_t;

    typedef struct packed {
        logic                      hit;
        logic [WAY_W-1:0]          way;
        logic [MOVE_W-1:0]         move;
        logic signed [SCORE_W-1:0] score;
        logic [DEPTH_W-1:0]        depth;
        logic [FLAG_W-1:0]         flag;
    } lookup_result_t;

    // Sparse copy of the cluster store; an entry never written reads as empty
    slot_t          slot_mem [int];
    logic [AGE_W-1:0] generation = '0;
    lookup_result_t awaited_results [$];

    function automatic slot_t read_slot(int idx);
        if (slot_mem.exists(idx)) begin
            return slot_mem[idx];
        end
        return '0;
    endfunction

    // Depth minus eight times the number of generations since the entry was written
    function automatic int slot_quality(slot_t s);
        int age_gap;
        age_gap = (AGE_PERIOD + int'(generation) - int'(s.age)) % AGE_PERIOD;
        return int'(s.depth) - (age_gap << AGE_SHIFT);
    endfunction

    // Apply one beat to the store copy and return the result it causes
    function automatic lookup_result_t apply_beat(
        logic [ACTION_W-1:0] act, logic [CLUSTER_W-1:0] cl, logic [FRAG_W-1:0] frag,
        logic [WAY_W-1:0] way, logic [MOVE_W-1:0] mv, logic signed [SCORE_W-1:0] score,
        logic [DEPTH_W-1:0] depth, logic [FLAG_W-1:0] flag, logic pv);
        lookup_result_t r;
        slot_t          s;
        int             base;
        int             pick;
        int             low;
        int             q;
        bit             matched;
        r    = '0;
        base = (int'(cl) % CLUSTERS) * WAYS;
        case (act)
            ACT_PROBE: begin
                // first empty or matching way, else the way of lowest quality
                pick = 0;
                s    = read_slot(base);
                if (s.frag != FRAG_EMPTY && s.frag != frag) begin
                    low = slot_quality(s);
                    for (int i = 1; i < WAYS; i++) begin
                        s = read_slot(base + i);
                        if (s.frag == FRAG_EMPTY || s.frag == frag) begin
                            pick = i;
                            break;
                        end
                        q = slot_quality(s);
                        if (q < low) begin
                            low  = q;
                            pick = i;
                        end
                    end
                end
                s       = read_slot(base + pick);
                r.hit   = (s.frag == frag);
                r.way   = WAY_W'(pick);
                r.move  = s.move;
                r.score = s.score;
                r.depth = s.depth;
                r.flag  = s.flag;
            end
            ACT_SAVE: begin
                if (int'(way) < WAYS) begin
                    s       = read_slot(base + int'(way));
                    matched = (s.frag == frag);
                    // keep the old move only when the tag matches and no new move is given
                    if (mv != '0 || !matched) begin
                        s.move = mv;
                    end
                    if (!matched || flag == FLAG_EXACT ||
                        int'(depth) + DEPTH_MARGIN + PV_MARGIN * int'(pv) >= int'(s.depth) ||
                        s.age != generation) begin
                        s.age   = generation;
                        s.score = score;
                        s.depth = depth;
                        s.flag  = flag;
                        s.frag  = frag;
                    end
                    slot_mem[base + int'(way)] = s;
                    r.way   = way;
                    r.move  = s.move;
                    r.score = s.score;
                    r.depth = s.depth;
                    r.flag  = s.flag;
                end
            end
            ACT_AGE: begin
                generation = AGE_W'((int'(generation) + 1) % AGE_PERIOD);
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    function automatic void check_field(string name, longint want, longint got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            o_fail_count++;
        end
    endfunction

    // Retire result beats against the oldest prediction, then queue new predictions
    always @(posedge i_clk) begin
        lookup_result_t want;
        if (!i_rst_n) begin
            slot_mem.delete();
            awaited_results.delete();
            generation   = '0;
            o_fail_count = 0;
            o_checked    = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (awaited_results.size() == 0) begin
                    $error("result beat arrived with no prediction waiting");
                    o_fail_count++;
                end else begin
                    want = awaited_results.pop_front();
                    check_field("hit", want.hit, i_hit);
                    check_field("chosen_way", want.way, i_chosen_way);
                    check_field("entry_move", want.move, i_entry_move);
                    check_field("entry_score", $signed(want.score), $signed(i_entry_score));
                    check_field("entry_depth", want.depth, i_entry_depth);
                    check_field("entry_flag", want.flag, i_entry_flag);
                    o_checked++;
                end
            end
            if (i_in_valid && !i_in_stall) begin
                awaited_results.push_back(apply_beat(i_action, i_cluster_index, i_fragment,
                    i_way, i_new_move, i_new_score, i_new_depth, i_new_flag, i_in_pv));
            end
        end
        o_pending = awaited_results.size();
    end

endmodule

@@ sim/tb.sv @@
// Testbench top for the clustered hash table core: stimulus, idling and verdict.
module tb;
    import chtr_pkg::*;

    localparam int     HALF_PERIOD  = 5;
    localparam int     PHASE_ITEMS  = 567;
    localparam int     DRAIN_LIMIT  = 4000;
    localparam int     TAIL_CYCLES  = 10;
    localparam longint RUN_LIMIT    = 5_000_000;

    // Codes the package leaves unnamed
    localparam logic [ACTION_W-1:0] ACT_SPARE   = 2'd3;
    localparam logic [FLAG_W-1:0]   FLAG_NONE   = 2'd0;
    localparam logic [FLAG_W-1:0]   FLAG_LOWER  = 2'd2;
    localparam logic [FLAG_W-1:0]   FLAG_UPPER  = 2'd3;
    localparam logic [WAY_W-1:0]    WAY_INVALID = 2'd3;

    typedef struct {
        logic [ACTION_W-1:0]       action;
        logic [CLUSTER_W-1:0]      cluster;
        logic [FRAG_W-1:0]         frag;
        logic [WAY_W-1:0]          way;
        logic [MOVE_W-1:0]         move;
        logic signed [SCORE_W-1:0] score;
        logic [DEPTH_W-1:0]        depth;
        logic [FLAG_W-1:0]         flag;
        logic                      pv;
    } beat_t;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      i_valid;
    logic                      o_stall;
    logic [ACTION_W-1:0]       i_action;
    logic [CLUSTER_W-1:0]      i_cluster_index;
    logic [FRAG_W-1:0]         i_fragment;
    logic [WAY_W-1:0]          i_way;
    logic [MOVE_W-1:0]         i_new_move;
    logic signed [SCORE_W-1:0] i_new_score;
    logic [DEPTH_W-1:0]        i_new_depth;
    logic [FLAG_W-1:0]         i_new_flag;
    logic                      i_in_pv;
    logic                      o_valid;
    logic                      i_stall;
    logic                      o_hit;
    logic [WAY_W-1:0]          o_chosen_way;
    logic [MOVE_W-1:0]         o_entry_move;
    logic signed [SCORE_W-1:0] o_entry_score;
    logic [DEPTH_W-1:0]        o_entry_depth;
    logic [FLAG_W-1:0]         o_entry_flag;

    int fail_count;
    int pending;
    int checked;
    int snd_idle_pct = 0;
    int rcv_idle_pct = 0;
    int n_probe = 0;
    int n_save  = 0;
    int n_age   = 0;
    int n_spare = 0;

    logic [WAY_W-1:0]     last_way = '0;
    logic [CLUSTER_W-1:0] hot_clusters [8];

    clustered_hash_table_replacement_core u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_action        (i_action),
        .i_cluster_index (i_cluster_index),
        .i_fragment      (i_fragment),
        .i_way           (i_way),
        .i_new_move      (i_new_move),
        .i_new_score     (i_new_score),
        .i_new_depth     (i_new_depth),
        .i_new_flag      (i_new_flag),
        .i_in_pv         (i_in_pv),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_hit           (o_hit),
        .o_chosen_way    (o_chosen_way),
        .o_entry_move    (o_entry_move),
        .o_entry_score   (o_entry_score),
        .o_entry_depth   (o_entry_depth),
        .o_entry_flag    (o_entry_flag)
    );

    hash_table_checker u_chk (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_valid),
        .i_in_stall      (o_stall),
        .i_action        (i_action),
        .i_cluster_index (i_cluster_index),
        .i_fragment      (i_fragment),
        .i_way           (i_way),
        .i_new_move      (i_new_move),
        .i_new_score     (i_new_score),
        .i_new_depth     (i_new_depth),
        .i_new_flag      (i_new_flag),
        .i_in_pv         (i_in_pv),
        .i_out_valid     (o_valid),
        .i_out_stall     (i_stall),
        .i_hit           (o_hit),
        .i_chosen_way    (o_chosen_way),
        .i_entry_move    (o_entry_move),
        .i_entry_score   (o_entry_score),
        .i_entry_depth   (o_entry_depth),
        .i_entry_flag    (o_entry_flag),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_checked       (checked)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // Receiver back-pressure, redrawn every cycle
    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
    end

    // Remember the way of the latest result beat so a save can follow its probe
    always @(posedge i_clk) begin
        if (o_valid && !i_stall) begin
            last_way <= o_chosen_way;
        end
    end

    // Hard stop in case the core hangs
    initial begin
        #(RUN_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    function automatic beat_t make_beat(
        logic [ACTION_W-1:0] act, logic [CLUSTER_W-1:0] cl, logic [FRAG_W-1:0] frag,
        logic [WAY_W-1:0] way, logic [MOVE_W-1:0] mv, logic signed [SCORE_W-1:0] score,
        logic [DEPTH_W-1:0] depth, logic [FLAG_W-1:0] flag, int pv);
        beat_t b;
        b.action  = act;
        b.cluster = cl;
        b.frag    = frag;
        b.way     = way;
        b.move    = mv;
        b.score   = score;
        b.depth   = depth;
        b.flag    = flag;
        b.pv      = 1'(pv);
        return b;
    endfunction

    // Mostly a few busy clusters so that ways fill up and collide
    function automatic logic [CLUSTER_W-1:0] pick_cluster();
        if ($urandom_range(0, 99) < 85) begin
            return hot_clusters[$urandom_range(0, 7)];
        end
        return CLUSTER_W'($urandom_range(0, 65535));
    endfunction

    // Mostly a handful of tags so that probes hit, now and then a wide or empty one
    function automatic logic [FRAG_W-1:0] pick_fragment();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 2) begin
            return FRAG_EMPTY;
        end
        if (sel < 14) begin
            return FRAG_W'($urandom_range(0, 65535));
        end
        return FRAG_W'($urandom_range(1, 5));
    endfunction

    function automatic beat_t random_beat();
        beat_t b;
        b.action  = ACTION_W'($urandom_range(0, 3));
        b.cluster = pick_cluster();
        b.frag    = pick_fragment();
        b.way     = WAY_W'($urandom_range(0, 3));
        b.move    = ($urandom_range(0, 3) == 0) ? '0 : MOVE_W'($urandom_range(0, 65535));
        b.score   = SCORE_W'($urandom());
        b.depth   = DEPTH_W'($urandom_range(0, 255));
        b.flag    = FLAG_W'($urandom_range(0, 3));
        b.pv      = 1'($urandom_range(0, 1));
        return b;
    endfunction

    // Offer one beat after a random idle spell and hold it until it is taken
    task automatic send_beat(input beat_t b);
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid         = 1'b1;
        i_action        = b.action;
        i_cluster_index = b.cluster;
        i_fragment      = b.frag;
        i_way           = b.way;
        i_new_move      = b.move;
        i_new_score     = b.score;
        i_new_depth     = b.depth;
        i_new_flag      = b.flag;
        i_in_pv         = b.pv;
        do begin
            @(posedge i_clk);
        end while (o_stall);
        @(negedge i_clk);
        case (b.action)
            ACT_PROBE: n_probe++;
            ACT_SAVE:  n_save++;
            ACT_AGE:   n_age++;
            default:   n_spare++;
        endcase
    endtask

    // Hold the input idle until every predicted result has come back or the wait limit is reached
    task automatic drain_results(input int max_cycles);
        int waited;
        waited  = 0;
        i_valid = 1'b0;
        while (pending != 0 && waited < max_cycles) begin
            @(negedge i_clk);
            waited++;
        end
    endtask

    initial begin
        beat_t                b;
        logic [CLUSTER_W-1:0] cl;
        logic [FRAG_W-1:0]    fr;
        int                   sel;
        int                   sent;

        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_stall         = 1'b0;
        i_action        = ACT_PROBE;
        i_cluster_index = '0;
        i_fragment      = '0;
        i_way           = '0;
        i_new_move      = '0;
        i_new_score     = '0;
        i_new_depth     = '0;
        i_new_flag      = FLAG_NONE;
        i_in_pv         = 1'b0;
        hot_clusters[0] = '0;
        hot_clusters[1] = '1;
        for (int i = 2; i < 8; i++) begin
            hot_clusters[i] = CLUSTER_W'($urandom_range(0, 65535));
        end
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: empty cluster, zero tag, extremes, keep and replace rules, spare codes
        send_beat(make_beat(ACT_PROBE, 16'd0, 16'hFFFF, 2'd0, 16'd0, 16'sd0, 8'd0, FLAG_NONE, 0));
        send_beat(make_beat(ACT_PROBE, 16'd0, FRAG_EMPTY, 2'd0, 16'd0, 16'sd0, 8'd0, FLAG_NONE, 0));
        send_beat(make_beat(ACT_SAVE, 16'd0, 16'hFFFF, 2'd0, 16'hFFFF, 16'sh8000, 8'd255,
                            FLAG_EXACT, 1));
        send_beat(make_beat(ACT_SAVE, 16'd0, 16'hFFFF, 2'd0, 16'd0, 16'sd123, 8'd0, FLAG_LOWER, 0));
        send_beat(make_beat(ACT_SAVE, 16'd0, 16'hFFFF, 2'd0, 16'd0, 16'sd7, 8'd252, FLAG_UPPER, 0));
        send_beat(make_beat(ACT_PROBE, 16'd0, 16'hFFFF, 2'd0, 16'd0, 16'sd0, 8'd0, FLAG_NONE, 0));
        send_beat(make_beat(ACT_SAVE, 16'd0, 16'd1, WAY_INVALID, 16'd9, 16'sd9, 8'd9, FLAG_EXACT, 1));
        send_beat(make_beat(ACT_AGE, 16'd0, 16'd0, 2'd0, 16'd0, 16'sd0, 8'd0, FLAG_NONE, 0));
        send_beat(make_beat(ACT_SPARE, 16'hFFFF, 16'hFFFF, 2'd3, 16'hFFFF, 16'sh7FFF, 8'd255,
                            FLAG_UPPER, 1));
        send_beat(make_beat(ACT_SAVE, 16'hFFFF, 16'd1, 2'd2, 16'd1, 16'sh7FFF, 8'd0, FLAG_NONE, 0));
        send_beat(make_beat(ACT_PROBE, 16'hFFFF, 16'd1, 2'd0, 16'd0, 16'sd0, 8'd0, FLAG_NONE, 0));
        // fill one cluster, then check the lowest-quality pick before and after an age step
        send_beat(make_beat(ACT_SAVE, 16'd5, 16'd10, 2'd0, 16'd100, 16'sd1, 8'd50, FLAG_LOWER, 0));
        send_beat(make_beat(ACT_SAVE, 16'd5, 16'd11, 2'd1, 16'd101, 16'sd2, 8'd20, FLAG_LOWER, 0));
        send_beat(make_beat(ACT_SAVE, 16'd5, 16'd12, 2'd2, 16'd102, 16'sd3, 8'd30, FLAG_LOWER, 0));
        send_beat(make_beat(ACT_PROBE, 16'd5, 16'd13, 2'd0, 16'd0, 16'sd0, 8'd0, FLAG_NONE, 0));
        send_beat(make_beat(ACT_AGE, 16'd5, 16'd0, 2'd0, 16'd0, 16'sd0, 8'd0, FLAG_NONE, 0));
        send_beat(make_beat(ACT_SAVE, 16'd5, 16'd12, 2'd2, 16'd0, -16'sd4, 8'd5, FLAG_UPPER, 0));
        send_beat(make_beat(ACT_PROBE, 16'd5, 16'd13, 2'd0, 16'd0, 16'sd0, 8'd0, FLAG_NONE, 0));
        // depth margin with and without the PV bonus
        send_beat(make_beat(ACT_SAVE, 16'd5, 16'd12, 2'd2, 16'd0, 16'sd5, 8'd0, FLAG_LOWER, 1));
        send_beat(make_beat(ACT_SAVE, 16'd5, 16'd12, 2'd2, 16'd0, 16'sd6, 8'd40, FLAG_LOWER, 0));
        send_beat(make_beat(ACT_SAVE, 16'd5, 16'd12, 2'd2, 16'h1234, 16'sd7, 8'd36, FLAG_UPPER, 0));
        send_beat(make_beat(ACT_SAVE, 16'd5, 16'd12, 2'd2, 16'd0, 16'sd8, 8'd35, FLAG_UPPER, 1));
        send_beat(make_beat(ACT_SAVE, 16'd5, 16'd99, 2'd1, 16'd0, 16'sd9, 8'd1, FLAG_NONE, 0));
        send_beat(make_beat(ACT_PROBE, 16'd5, 16'd12, 2'd0, 16'd0, 16'sd0, 8'd0, FLAG_NONE, 0));
        send_beat(make_beat(ACT_SAVE, 16'd1, FRAG_EMPTY, 2'd0, 16'd3, 16'sd3, 8'd3, FLAG_EXACT, 0));
        drain_results(DRAIN_LIMIT);

        // Random: probe-then-save pairs with random content, age steps and noise
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    snd_idle_pct = 22;
                    rcv_idle_pct = 58;
                end
                1: begin
                    snd_idle_pct = 58;
                    rcv_idle_pct = 22;
                end
                default: begin
                    snd_idle_pct = 0;
                    rcv_idle_pct = 0;
                end
            endcase
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                sel = $urandom_range(0, 99);
                if (sel < 60) begin
                    cl       = pick_cluster();
                    fr       = pick_fragment();
                    b        = random_beat();
                    b.action = ACT_PROBE;
                    b.cluster = cl;
                    b.frag   = fr;
                    send_beat(b);
                    drain_results(DRAIN_LIMIT);
                    b        = random_beat();
                    b.action = ACT_SAVE;
                    b.cluster = cl;
                    b.frag   = ($urandom_range(0, 99) < 85) ? fr : pick_fragment();
                    b.way    = ($urandom_range(0, 99) < 92) ? last_way
                                                            : WAY_W'($urandom_range(0, 3));
                    send_beat(b);
                    sent += 2;
                end else if (sel < 66) begin
                    b        = random_beat();
                    b.action = ACT_AGE;
                    send_beat(b);
                    sent++;
                end else begin
                    send_beat(random_beat());
                    sent++;
                end
            end
        end

        drain_results(DRAIN_LIMIT);
        repeat (TAIL_CYCLES) @(negedge i_clk);

        $display("Covered %0d probes, %0d saves, %0d age steps and %0d spare-code beats",
                 n_probe, n_save, n_age, n_spare);
        $display("over three idling phases; %0d result beats compared, %0d still awaited",
                 checked, pending);
        if (fail_count == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
